// File: sv/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg - shared types, codes and field arithmetic
// GF(2^8) helpers for the digit-serial multiply, command codes,
// register indexes and the control group between sequencer and mac.
// ----------------------------------------------------------------------------
package gbe_pkg;

   // field polynomial x^8+x^4+x^3+x^2+1, low eight bits
   localparam logic [7:0] FIELD_POLY = 8'h1d;

   // multiplier digit, bits of the generator entry consumed per cycle
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = 8 / DIGIT_W;

   // request kinds carried in tuser
   localparam logic [1:0] FUNC_LOAD_GEN  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_DATA = 2'd1;
   localparam logic [1:0] FUNC_ENCODE    = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_DATA_COUNT   = 2'd0;
   localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;

   localparam logic [4:0] DATA_COUNT_RESET   = 5'd16;
   localparam logic [5:0] BLOCK_LENGTH_RESET = 6'd32;

   typedef struct packed {
      logic clear;   // zero the accumulator
      logic load;    // take new operands
      logic step;    // fold one digit product into the accumulator
   } gbe_mac_ctl_type;

   // multiply by alpha
   function automatic logic [7:0] gf_xtime(input logic [7:0] x);
      logic [7:0] r;
      r = {x[6:0], 1'b0};
      if (x[7]) begin
         r = r ^ FIELD_POLY;
      end
      return r;
   endfunction

   // x times a digit-wide field element
   function automatic logic [7:0] gf_mul_digit(input logic [7:0] x,
                                               input logic [DIGIT_W-1:0] d);
      logic [7:0] r;
      logic [7:0] s;
      r = '0;
      s = x;
      for (int j = 0; j < DIGIT_W; j++) begin
         if (d[j]) begin
            r = r ^ s;
         end
         s = gf_xtime(s);
      end
      return r;
   endfunction

   // x times alpha^DIGIT_W
   function automatic logic [7:0] gf_shift_digit(input logic [7:0] x);
      logic [7:0] s;
      s = x;
      for (int j = 0; j < DIGIT_W; j++) begin
         s = gf_xtime(s);
      end
      return s;
   endfunction

endpackage

// File: sv/gbe_mac.sv
// ----------------------------------------------------------------------------
// gbe_mac - digit-serial GF(2^8) multiply-accumulate
// The generator byte shifts out one digit per cycle while step is high; the data byte
// is scaled by alpha^digit; each digit product is xored into the sum.
// ----------------------------------------------------------------------------
module gbe_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  gbe_pkg::gbe_mac_ctl_type ctl,
   input  logic [7:0]               data_byte,
   input  logic [7:0]               gen_byte,
   output logic [7:0]               acc
);

   logic [7:0] x_ff, x_in;
   logic [7:0] b_ff, b_in;
   logic [7:0] acc_ff, acc_in;

   always_comb begin
      x_in   = x_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      if (ctl.step) begin
         acc_in = acc_ff ^ gbe_pkg::gf_mul_digit(x_ff, b_ff[gbe_pkg::DIGIT_W-1:0]);
         x_in   = gbe_pkg::gf_shift_digit(x_ff);
         b_in   = b_ff >> gbe_pkg::DIGIT_W;
      end
      if (ctl.clear) begin
         acc_in = '0;
      end
      if (ctl.load) begin
         x_in = data_byte;
         b_in = gen_byte;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      b_ff <= b_in;
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

   a_clear_zeroes : assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> acc_ff == 8'd0)
      else $error("accumulator not cleared");

   a_idle_holds : assert property (@(posedge clock) disable iff (reset)
      (!ctl.clear && !ctl.step) |=> $stable(acc_ff))
      else $error("accumulator moved without a step");

   a_no_clear_step : assert property (@(posedge clock) disable iff (reset)
      !(ctl.clear && ctl.step))
      else $error("clear and step together");

endmodule

// File: sv/gf256_block_erasure_encoder.sv
// ----------------------------------------------------------------------------
// gf256_block_erasure_encoder - GF(2^8) linear block erasure encoder
// Stores a generator matrix and a block of data symbols; an encode request
// returns codeword symbol t, plus all parity symbols when t is the last
// data position. Products are formed digit-serially in gbe_mac.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   req_tvalid/tready  tuser func; tdata row, column, value
//  rsp      out  rsp_tvalid/tready  tdata symbol, position; tlast last
//  csr      in   csr_valid/ready    csr_index, csr_data
//
//  loads are taken from the idle state; an encode symbol steps through fetch,
//  prime, a multiply-accumulate loop over the 4-bit digits of each of k rows, and emit.
//  a run of parity symbols repeats that per symbol; one request at a time.
//  a symbol waits in the output register while the next one is computed;
//  the sequencer stalls only when that register is still full.
//  reset is synchronous; matrix and data stores are not cleared.
// ----------------------------------------------------------------------------
module gf256_block_erasure_encoder #(
   parameter int MAX_DATA   = 16,
   parameter int MAX_LENGTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // req
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // row[3:0], column[8:4], value[16:9]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // rsp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // symbol[7:0], position[12:8]
   output logic        rsp_tlast,
   // csr
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);

   localparam int ROW_W     = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int COL_W     = $clog2(MAX_LENGTH);
   localparam int CNT_W     = $clog2(MAX_DATA + 1);
   localparam int LEN_W     = $clog2(MAX_LENGTH + 1);
   localparam int GEN_DEPTH = MAX_DATA * (1 << COL_W);
   localparam int GA_W      = $clog2(GEN_DEPTH);
   localparam int DIG_CNT_W = (gbe_pkg::DIGITS > 1) ? $clog2(gbe_pkg::DIGITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PRIME,
      ST_MAC,
      ST_EMIT
   } state_type;

   state_type                  state_ff;
   logic [4:0]                 data_count_ff;
   logic [5:0]                 block_length_ff;
   logic [COL_W-1:0]           col_ff;
   logic [COL_W-1:0]           end_ff;
   logic [CNT_W-1:0]           f_ff;
   logic [CNT_W-1:0]           l_ff;
   logic [DIG_CNT_W-1:0]       d_ff;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_symbol_ff;
   logic [4:0]                 rsp_position_ff;
   logic                       rsp_last_ff;

   logic [7:0] gen_mem  [GEN_DEPTH];
   logic [7:0] data_mem [MAX_DATA];
   logic [7:0] gen_rd_ff;
   logic [7:0] data_rd_ff;

   logic [1:0]  req_func;
   logic [3:0]  req_row;
   logic [4:0]  req_column;
   logic [7:0]  req_value;
   logic        req_beat;
   logic        wr_gen;
   logic        wr_data;
   logic        start_enc;
   logic [CNT_W-1:0] k_eff;
   logic [LEN_W-1:0] n_eff;
   logic        last_digit;
   logic        more_rows;
   logic        rd_en;
   logic        rsp_free;
   logic        rsp_load;
   logic [7:0]  acc;
   gbe_pkg::gbe_mac_ctl_type mac_ctl;

   assign req_func   = req_tuser;
   assign req_row    = req_tdata[3:0];
   assign req_column = req_tdata[8:4];
   assign req_value  = req_tdata[16:9];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // effective k and n, saturated
   always_comb begin
      if (data_count_ff == 5'd0) begin
         k_eff = CNT_W'(1);
      end else if (int'(data_count_ff) > MAX_DATA) begin
         k_eff = CNT_W'(MAX_DATA);
      end else begin
         k_eff = CNT_W'(data_count_ff);
      end
      if (int'(block_length_ff) < int'(k_eff)) begin
         n_eff = LEN_W'(k_eff);
      end else if (int'(block_length_ff) > MAX_LENGTH) begin
         n_eff = LEN_W'(MAX_LENGTH);
      end else begin
         n_eff = LEN_W'(block_length_ff);
      end
   end

   assign wr_gen    = req_beat && (req_func == gbe_pkg::FUNC_LOAD_GEN)
                      && (int'(req_row) < MAX_DATA) && (int'(req_column) < MAX_LENGTH);
   assign wr_data   = req_beat && (req_func == gbe_pkg::FUNC_LOAD_DATA)
                      && (int'(req_row) < MAX_DATA);
   assign start_enc = req_beat && (req_func == gbe_pkg::FUNC_ENCODE)
                      && (int'(req_column) < int'(n_eff));

   assign last_digit = (int'(d_ff) == gbe_pkg::DIGITS - 1);
   assign more_rows  = (l_ff < k_eff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_EMIT) && rsp_free;

   always_comb begin
      case (state_ff)
         ST_FETCH: rd_en = 1'b1;
         ST_PRIME: rd_en = (f_ff < k_eff);
         ST_MAC:   rd_en = last_digit && more_rows && (f_ff < k_eff);
         default:  rd_en = 1'b0;
      endcase
   end

   always_comb begin
      mac_ctl.clear = start_enc || (rsp_load && (col_ff != end_ff));
      mac_ctl.load  = (state_ff == ST_PRIME)
                      || ((state_ff == ST_MAC) && last_digit && more_rows);
      mac_ctl.step  = (state_ff == ST_MAC);
   end

   // generator matrix, row-major with columns padded to a power of two
   always_ff @(posedge clock) begin
      if (wr_gen) begin
         gen_mem[GA_W'({ROW_W'(req_row), COL_W'(req_column)})] <= req_value;
      end
      if (rd_en) begin
         gen_rd_ff <= gen_mem[GA_W'({f_ff[ROW_W-1:0], col_ff})];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_data) begin
         data_mem[ROW_W'(req_row)] <= req_value;
      end
      if (rd_en) begin
         data_rd_ff <= data_mem[f_ff[ROW_W-1:0]];
      end
   end

   gbe_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .data_byte (data_rd_ff),
      .gen_byte  (gen_rd_ff),
      .acc       (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         data_count_ff   <= gbe_pkg::DATA_COUNT_RESET;
         block_length_ff <= gbe_pkg::BLOCK_LENGTH_RESET;
         f_ff            <= '0;
         l_ff            <= '0;
         d_ff            <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gbe_pkg::REG_DATA_COUNT:   data_count_ff   <= csr_data[4:0];
               gbe_pkg::REG_BLOCK_LENGTH: block_length_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start_enc) begin
                  col_ff <= COL_W'(req_column);
                  f_ff   <= '0;
                  if (int'(req_column) == int'(k_eff) - 1) begin
                     end_ff <= COL_W'(int'(n_eff) - 1);
                  end else begin
                     end_ff <= COL_W'(req_column);
                  end
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               f_ff     <= CNT_W'(1);
               l_ff     <= '0;
               state_ff <= ST_PRIME;
            end
            ST_PRIME: begin
               l_ff     <= CNT_W'(1);
               d_ff     <= '0;
               if (f_ff < k_eff) begin
                  f_ff <= f_ff + CNT_W'(1);
               end
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               if (last_digit) begin
                  d_ff <= '0;
                  if (more_rows) begin
                     l_ff <= l_ff + CNT_W'(1);
                     if (f_ff < k_eff) begin
                        f_ff <= f_ff + CNT_W'(1);
                     end
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  d_ff <= d_ff + DIG_CNT_W'(1);
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_symbol_ff   <= acc;
                  rsp_position_ff <= 5'(col_ff);
                  rsp_last_ff     <= (col_ff == end_ff);
                  if (col_ff == end_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     col_ff   <= col_ff + COL_W'(1);
                     f_ff     <= '0;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_position_ff, rsp_symbol_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_row_counts : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (l_ff <= f_ff) && (f_ff <= k_eff))
      else $error("row counters out of order");

   a_all_rows_in : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (l_ff == k_eff))
      else $error("symbol emitted before all rows accumulated");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_run_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (col_ff <= end_ff))
      else $error("position ran past end of run");

endmodule
